>>> rtl/cfpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpb_pkg
// Shared constants, types and the CRC-16/MODBUS byte update for the packet
// builder.
// ----------------------------------------------------------------------------
package cfpb_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;

    localparam int    MAX_PAYLOAD  = 247;
    localparam int    MAX_RESULTS  = 9;
    localparam int    CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam crc_t  CRC_INIT     = 16'hFFFF;
    localparam crc_t  CRC_POLY     = 16'hA001;
    localparam byte_t TRAILER_HI   = 8'hDD;
    localparam byte_t TRAILER_LO   = 8'hEE;
    localparam crc_t  LEN_EXTRA    = 16'd2;

    typedef logic [CNT_W-1:0] res_cnt_t;

    // Fold one byte into a running CRC-16/MODBUS value, LSB first.
    function automatic crc_t crc16_feed(input crc_t crc_in, input byte_t data);
        crc_t c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> rtl/crc_framed_packet_builder.sv
`timescale 1ns / 1ps
// The first result byte of an accepted item is registered and is on m_* in the next cycle.
// Throughput: one result byte per cycle while m_tready is high, set by the single-byte
// output port; an item's results stay in the output register until all have gone, and the
// next item is taken in the cycle the last of them transfers (every cycle, while m_tready
// is high, for items with at most one result, and every cycle for items with no result).
// Reset: rst_n loads the CRC seed, clears counters and flags and empties the output register.
// ----------------------------------------------------------------------------
// crc_framed_packet_builder
// Turns a stream of payload items into framed packets: command, payload,
// length, CRC-16/MODBUS and the DD EE trailer, one byte per output transfer.
// ----------------------------------------------------------------------------
module crc_framed_packet_builder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] frame_code, [23:16] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // frame_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] run_last, [1] overflow
    output logic        m_tlast    // frame_last
);
    import cfpb_pkg::*;

    // Frame state
    crc_t     crc_reg,           crc_next;
    byte_t    payload_count_reg, payload_count_next;
    logic     in_frame_reg,      in_frame_next;
    logic     dropped_reg,       dropped_next;

    // Result register: bytes still to send, front at index 0
    byte_t    res_reg [MAX_RESULTS];
    res_cnt_t res_cnt_reg;
    logic     res_close_reg;
    logic     res_ovf_reg;

    byte_t    burst [MAX_RESULTS];
    res_cnt_t n;
    logic     s_xfer;
    logic     m_xfer;

    byte_t    code_hi, code_lo, data_byte;
    logic     has_byte, frame_end;
    crc_t     len;

    assign code_hi   = s_tdata[15:8];
    assign code_lo   = s_tdata[7:0];
    assign data_byte = s_tdata[23:16];
    assign has_byte  = s_tuser[0];
    assign frame_end = s_tlast;

    assign m_tvalid = (res_cnt_reg != '0);
    assign m_xfer   = m_tvalid && m_tready;
    // Take a new item when nothing is pending or the last pending byte leaves this cycle
    assign s_tready = (res_cnt_reg == '0) || ((res_cnt_reg == res_cnt_t'(1)) && m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    assign m_tdata  = res_reg[0];
    assign m_tlast  = res_close_reg && (res_cnt_reg == res_cnt_t'(1));
    assign m_tuser  = {res_ovf_reg, (res_cnt_reg == res_cnt_t'(1))};

    // Build the whole burst for one item
    always_comb
    begin
        crc_next           = crc_reg;
        payload_count_next = payload_count_reg;
        dropped_next       = dropped_reg;
        in_frame_next      = 1'b1;
        n                  = '0;
        len                = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
            burst[i] = '0;

        if (!in_frame_reg)
        begin
            payload_count_next = '0;
            dropped_next       = 1'b0;
            crc_next           = crc16_feed(crc16_feed(CRC_INIT, code_hi), code_lo);
            burst[0]           = code_hi;
            burst[1]           = code_lo;
            n                  = res_cnt_t'(2);
        end

        if (has_byte)
        begin
            if (payload_count_next < byte_t'(MAX_PAYLOAD))
            begin
                crc_next           = crc16_feed(crc_next, data_byte);
                payload_count_next = payload_count_next + byte_t'(1);
                burst[n]           = data_byte;
                n                  = n + res_cnt_t'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (frame_end)
        begin
            len      = {8'h00, payload_count_next} + LEN_EXTRA;
            crc_next = crc16_feed(crc16_feed(crc_next, len[15:8]), len[7:0]);
            burst[n]                   = len[15:8];
            burst[n + res_cnt_t'(1)]   = len[7:0];
            burst[n + res_cnt_t'(2)]   = crc_next[15:8];
            burst[n + res_cnt_t'(3)]   = crc_next[7:0];
            burst[n + res_cnt_t'(4)]   = TRAILER_HI;
            burst[n + res_cnt_t'(5)]   = TRAILER_LO;
            n                          = n + res_cnt_t'(6);
        end
    end

    // Frame state: update on each accepted item; drop back to idle values once a frame closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg           <= CRC_INIT;
            payload_count_reg <= '0;
            in_frame_reg      <= 1'b0;
            dropped_reg       <= 1'b0;
        end
        else if (s_xfer)
        begin
            if (frame_end)
            begin
                crc_reg           <= CRC_INIT;
                payload_count_reg <= '0;
                in_frame_reg      <= 1'b0;
                dropped_reg       <= 1'b0;
            end
            else
            begin
                crc_reg           <= crc_next;
                payload_count_reg <= payload_count_next;
                in_frame_reg      <= in_frame_next;
                dropped_reg       <= dropped_next;
            end
        end
    end

    // Result register: load a burst, or advance by one byte per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg   <= '0;
            res_close_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end
        else if (s_xfer)
        begin
            res_cnt_reg   <= n;
            res_close_reg <= frame_end;
            res_ovf_reg   <= dropped_next;
        end
        else if (m_xfer)
        begin
            res_cnt_reg <= res_cnt_reg - res_cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
                res_reg[i] <= burst[i];
        end
        else if (m_xfer)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                res_reg[i] <= res_reg[i + 1];
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= res_cnt_t'(MAX_RESULTS))
        else $error("result count out of range");

    a_payload_range: assert property (@(posedge clk) disable iff (!rst_n)
        payload_count_reg <= byte_t'(MAX_PAYLOAD))
        else $error("payload count beyond limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |-> (res_cnt_reg == '0) || (res_cnt_reg == res_cnt_t'(1) && m_xfer))
        else $error("item taken while results still pending");

    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && frame_end) |=> !in_frame_reg && (crc_reg == CRC_INIT))
        else $error("frame state not cleared after close");

    a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser[0] && (m_tdata == TRAILER_LO))
        else $error("frame end not on final trailer byte");

endmodule
